@@ rtl/core/team_grouped_queue_core_defines.svh @@
// Assertion macros used by the checker file tgq_chk.
`ifndef TEAM_GROUPED_QUEUE_CORE_DEFINES_SVH
`define TEAM_GROUPED_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tgq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TGQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tgq assertion failed");

`endif

@@ rtl/core/tgq_pkg.sv @@
package tgq_pkg;

    localparam int MEMBER_IDS = 1024;
    localparam int MAX_TEAMS  = 64;
    localparam int CAPACITY   = 1024;

    localparam int ACTION_W = 2;
    localparam int MEMBER_W = 10;
    localparam int TEAM_W   = 6;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RING_W   = $clog2(MAX_TEAMS);

    localparam logic [ACTION_W-1:0] ACT_ASSIGN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_E2,
        ST_E3,
        ST_D2,
        ST_D3,
        ST_D4,
        ST_OUT
    } t_state;

    function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] p);
        return (p == RING_W'(MAX_TEAMS - 1)) ? '0 : p + RING_W'(1);
    endfunction

endpackage

@@ rtl/core/tgq_if.sv @@
interface tgq_in_if;
    logic                          valid;
    logic                          ready;
    logic [tgq_pkg::ACTION_W-1:0]  action;
    logic [tgq_pkg::MEMBER_W-1:0]  member;
    logic [tgq_pkg::TEAM_W-1:0]    team_id;

    modport source (output valid, output action, output member, output team_id,
                    input ready);
    modport sink   (input valid, input action, input member, input team_id,
                    output ready);
endinterface

interface tgq_out_if;
    logic                          valid;
    logic                          ready;
    logic [tgq_pkg::MEMBER_W-1:0]  out_member;
    logic                          out_valid;
    logic [tgq_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output out_member, output out_valid, output status,
                    input ready);
    modport sink   (input valid, input out_member, input out_valid, input status,
                    output ready);
endinterface

@@ rtl/core/tgq_ram.sv @@
module tgq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/team_grouped_queue_core.sv @@
// Each input beat walks a chain of states: assign goes straight to ST_OUT, enqueue
// through E2 and E3, dequeue through D2, D3 and D4 (a failed enqueue or dequeue goes
// straight to ST_OUT). The next input beat is taken only once the result is loaded into
// the output register, so one item is in flight; the chain follows the registered reads
// through the team, slot and order memories. Synchronous active-low reset; afterwards a
// clearing pass zeroes all 1024 member-to-team entries while no input beat is accepted.
module team_grouped_queue_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgq_in_if.sink     i_in,
    tgq_out_if.source  o_out
);

    tgq_pkg::t_state r_state, n_state;

    logic [tgq_pkg::MEMBER_W-1:0] r_clr, n_clr;
    logic [tgq_pkg::MEMBER_W-1:0] r_mem, n_mem;
    logic [tgq_pkg::TEAM_W-1:0]   r_t, n_t;
    logic [tgq_pkg::SLOT_W-1:0]   r_s, n_s;
    logic [tgq_pkg::SLOT_W-1:0]   r_last, n_last;
    logic [tgq_pkg::SLOT_W-1:0]   r_free_head, n_free_head;
    logic [tgq_pkg::CNT_W-1:0]    r_fresh, n_fresh;
    logic [tgq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [tgq_pkg::RING_W-1:0]   r_rp, n_rp;
    logic [tgq_pkg::RING_W-1:0]   r_wp, n_wp;
    logic [tgq_pkg::MAX_TEAMS-1:0] r_waiting, n_waiting;
    logic [tgq_pkg::MEMBER_W-1:0] r_res_member, n_res_member;
    logic                         r_res_valid, n_res_valid;
    logic [tgq_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                         r_ovalid, n_ovalid;
    logic [tgq_pkg::MEMBER_W-1:0] r_out_member, n_out_member;
    logic                         r_out_valid, n_out_valid;
    logic [tgq_pkg::STATUS_W-1:0] r_out_status, n_out_status;

    logic accept;
    logic out_load;
    logic [tgq_pkg::SLOT_W-1:0] s_alloc;

    logic                          tom_we;
    logic [tgq_pkg::MEMBER_W-1:0]  tom_waddr, tom_raddr;
    logic [tgq_pkg::TEAM_W-1:0]    tom_wdata, tom_rdata;
    logic                          smem_we;
    logic [tgq_pkg::SLOT_W-1:0]    smem_waddr, smem_raddr;
    logic [tgq_pkg::MEMBER_W-1:0]  smem_wdata, smem_rdata;
    logic                          snext_we;
    logic [tgq_pkg::SLOT_W-1:0]    snext_waddr, snext_raddr, snext_wdata, snext_rdata;
    logic                          first_we;
    logic [tgq_pkg::TEAM_W-1:0]    first_waddr, first_raddr;
    logic [tgq_pkg::SLOT_W-1:0]    first_wdata, first_rdata;
    logic                          last_we;
    logic [tgq_pkg::TEAM_W-1:0]    last_waddr, last_raddr;
    logic [tgq_pkg::SLOT_W-1:0]    last_wdata, last_rdata;
    logic                          ring_we;
    logic [tgq_pkg::RING_W-1:0]    ring_waddr, ring_raddr;
    logic [tgq_pkg::TEAM_W-1:0]    ring_wdata, ring_rdata;

    assign accept   = i_in.valid && i_in.ready;
    assign out_load = (r_state == tgq_pkg::ST_OUT) && (!r_ovalid || o_out.ready);
    // Reuse a freed slot while the free list holds any, else take a fresh one.
    assign s_alloc  = (r_fresh > r_count) ? r_free_head : r_fresh[tgq_pkg::SLOT_W-1:0];

    assign o_out.valid      = r_ovalid;
    assign o_out.out_member = r_out_member;
    assign o_out.out_valid  = r_out_valid;
    assign o_out.status     = r_out_status;

    tgq_ram #(.DEPTH(tgq_pkg::MEMBER_IDS), .WIDTH(tgq_pkg::TEAM_W)) u_tom (
        .i_clk(i_clk), .i_we(tom_we), .i_waddr(tom_waddr), .i_wdata(tom_wdata),
        .i_raddr(tom_raddr), .o_rdata(tom_rdata));
    tgq_ram #(.DEPTH(tgq_pkg::CAPACITY), .WIDTH(tgq_pkg::MEMBER_W)) u_smem (
        .i_clk(i_clk), .i_we(smem_we), .i_waddr(smem_waddr), .i_wdata(smem_wdata),
        .i_raddr(smem_raddr), .o_rdata(smem_rdata));
    tgq_ram #(.DEPTH(tgq_pkg::CAPACITY), .WIDTH(tgq_pkg::SLOT_W)) u_snext (
        .i_clk(i_clk), .i_we(snext_we), .i_waddr(snext_waddr), .i_wdata(snext_wdata),
        .i_raddr(snext_raddr), .o_rdata(snext_rdata));
    tgq_ram #(.DEPTH(tgq_pkg::MAX_TEAMS), .WIDTH(tgq_pkg::SLOT_W)) u_first (
        .i_clk(i_clk), .i_we(first_we), .i_waddr(first_waddr), .i_wdata(first_wdata),
        .i_raddr(first_raddr), .o_rdata(first_rdata));
    tgq_ram #(.DEPTH(tgq_pkg::MAX_TEAMS), .WIDTH(tgq_pkg::SLOT_W)) u_last (
        .i_clk(i_clk), .i_we(last_we), .i_waddr(last_waddr), .i_wdata(last_wdata),
        .i_raddr(last_raddr), .o_rdata(last_rdata));
    tgq_ram #(.DEPTH(tgq_pkg::MAX_TEAMS), .WIDTH(tgq_pkg::TEAM_W)) u_ring (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(ring_waddr), .i_wdata(ring_wdata),
        .i_raddr(ring_raddr), .o_rdata(ring_rdata));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tgq_pkg::ST_CLEAR: begin
                if (r_clr == tgq_pkg::MEMBER_W'(tgq_pkg::MEMBER_IDS - 1)) begin
                    n_state = tgq_pkg::ST_IDLE;
                end
            end
            tgq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in.action == tgq_pkg::ACT_ENQUEUE &&
                        r_count < tgq_pkg::CNT_W'(tgq_pkg::CAPACITY)) begin
                        n_state = tgq_pkg::ST_E2;
                    end else if (i_in.action == tgq_pkg::ACT_DEQUEUE && r_count != '0) begin
                        n_state = tgq_pkg::ST_D2;
                    end else begin
                        n_state = tgq_pkg::ST_OUT;
                    end
                end
            end
            tgq_pkg::ST_E2: n_state = tgq_pkg::ST_E3;
            tgq_pkg::ST_E3: n_state = tgq_pkg::ST_OUT;
            tgq_pkg::ST_D2: n_state = tgq_pkg::ST_D3;
            tgq_pkg::ST_D3: n_state = tgq_pkg::ST_D4;
            tgq_pkg::ST_D4: n_state = tgq_pkg::ST_OUT;
            tgq_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = tgq_pkg::ST_IDLE;
                end
            end
            default: n_state = tgq_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and input ready.
    always_comb begin
        i_in.ready  = (r_state == tgq_pkg::ST_IDLE);
        tom_we      = 1'b0;
        tom_waddr   = i_in.member;
        tom_wdata   = i_in.team_id;
        tom_raddr   = i_in.member;
        smem_we     = 1'b0;
        smem_waddr  = s_alloc;
        smem_wdata  = r_mem;
        smem_raddr  = first_rdata;
        snext_we    = 1'b0;
        snext_waddr = s_alloc;
        snext_wdata = '0;
        snext_raddr = (r_state == tgq_pkg::ST_D3) ? first_rdata : r_free_head;
        first_we    = 1'b0;
        first_waddr = r_t;
        first_wdata = r_s;
        first_raddr = ring_rdata;
        last_we     = 1'b0;
        last_waddr  = r_t;
        last_wdata  = r_s;
        last_raddr  = (r_state == tgq_pkg::ST_E2) ? tom_rdata : ring_rdata;
        ring_we     = 1'b0;
        ring_waddr  = r_wp;
        ring_wdata  = r_t;
        ring_raddr  = r_rp;
        unique case (r_state)
            tgq_pkg::ST_CLEAR: begin
                tom_we    = 1'b1;
                tom_waddr = r_clr;
                tom_wdata = '0;
            end
            tgq_pkg::ST_IDLE: begin
                tom_we = accept && (i_in.action == tgq_pkg::ACT_ASSIGN);
            end
            tgq_pkg::ST_E2: begin
                smem_we  = 1'b1;
                snext_we = 1'b1;
            end
            tgq_pkg::ST_E3: begin
                last_we = 1'b1;
                if (r_waiting[r_t]) begin
                    snext_we    = 1'b1;
                    snext_waddr = last_rdata;
                    snext_wdata = r_s;
                end else begin
                    first_we = 1'b1;
                    ring_we  = 1'b1;
                end
            end
            tgq_pkg::ST_D4: begin
                snext_we    = 1'b1;
                snext_waddr = r_s;
                snext_wdata = r_free_head;
                first_we    = (r_s != r_last);
                first_wdata = snext_rdata;
            end
            tgq_pkg::ST_D2, tgq_pkg::ST_D3, tgq_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_clr        = r_clr;
        n_mem        = r_mem;
        n_t          = r_t;
        n_s          = r_s;
        n_last       = r_last;
        n_free_head  = r_free_head;
        n_fresh      = r_fresh;
        n_count      = r_count;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_waiting    = r_waiting;
        n_res_member = r_res_member;
        n_res_valid  = r_res_valid;
        n_res_status = r_res_status;
        unique case (r_state)
            tgq_pkg::ST_CLEAR: n_clr = r_clr + tgq_pkg::MEMBER_W'(1);
            tgq_pkg::ST_IDLE: begin
                n_mem        = i_in.member;
                n_res_member = '0;
                n_res_valid  = 1'b0;
                n_res_status = tgq_pkg::STAT_OK;
                if (i_in.action == tgq_pkg::ACT_ENQUEUE &&
                    r_count >= tgq_pkg::CNT_W'(tgq_pkg::CAPACITY)) begin
                    n_res_status = tgq_pkg::STAT_FULL;
                end else if (i_in.action == tgq_pkg::ACT_DEQUEUE && r_count == '0) begin
                    n_res_status = tgq_pkg::STAT_EMPTY;
                end
            end
            tgq_pkg::ST_E2: begin
                n_t = tom_rdata;
                n_s = s_alloc;
                if (r_fresh > r_count) begin
                    n_free_head = snext_rdata;
                end else begin
                    n_fresh = r_fresh + tgq_pkg::CNT_W'(1);
                end
            end
            tgq_pkg::ST_E3: begin
                if (!r_waiting[r_t]) begin
                    n_waiting[r_t] = 1'b1;
                    n_wp           = tgq_pkg::ring_next(r_wp);
                end
                n_count = r_count + tgq_pkg::CNT_W'(1);
            end
            tgq_pkg::ST_D2: n_t = ring_rdata;
            tgq_pkg::ST_D3: begin
                n_s    = first_rdata;
                n_last = last_rdata;
            end
            tgq_pkg::ST_D4: begin
                n_res_member = smem_rdata;
                n_res_valid  = 1'b1;
                if (r_s == r_last) begin
                    n_waiting[r_t] = 1'b0;
                    n_rp           = tgq_pkg::ring_next(r_rp);
                end
                n_free_head = r_s;
                n_count     = r_count - tgq_pkg::CNT_W'(1);
            end
            tgq_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a result beat until the sink takes it.
    always_comb begin
        n_ovalid     = r_ovalid;
        n_out_member = r_out_member;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        if (out_load) begin
            n_ovalid     = 1'b1;
            n_out_member = r_res_member;
            n_out_valid  = r_res_valid;
            n_out_status = r_res_status;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tgq_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_waiting   <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_count     <= n_count;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_waiting   <= n_waiting;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem        <= n_mem;
        r_t          <= n_t;
        r_s          <= n_s;
        r_last       <= n_last;
        r_res_member <= n_res_member;
        r_res_valid  <= n_res_valid;
        r_res_status <= n_res_status;
        r_out_member <= n_out_member;
        r_out_valid  <= n_out_valid;
        r_out_status <= n_out_status;
    end

endmodule

@@ rtl/core/tgq_chk.sv @@
`include "team_grouped_queue_core_defines.svh"

module tgq_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [tgq_pkg::MEMBER_W-1:0] i_out_member,
    input logic                         i_out_flag,
    input logic [tgq_pkg::STATUS_W-1:0] i_out_status
);

    // A stalled result beat keeps its payload.
    `TGQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_member) && $stable(i_out_flag) && $stable(i_out_status))
    // One item is worked on at a time.
    `TGQ_ASSERT_NEXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready)
    // A dequeued member always comes with an ok status.
    `TGQ_ASSERT_NOW(a_member_ok, i_out_valid && i_out_flag, i_out_status == tgq_pkg::STAT_OK)
    // Without a dequeued member the member field is zero.
    `TGQ_ASSERT_NOW(a_member_zero, i_out_valid && !i_out_flag, i_out_member == '0)

endmodule

bind team_grouped_queue_core tgq_chk u_tgq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_member (o_out.out_member),
    .i_out_flag   (o_out.out_valid),
    .i_out_status (o_out.status)
);
